// ----- design/idmd_pkg.sv -----
// Shared constants, request codes, sequencer states and divider request type.
package idmd_pkg;

  localparam int MAX_CONTROLS_DEF = 16;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int RAW_SHIFT = 58;
  localparam int QW        = RAW_SHIFT + 1;
  localparam int DW        = 64;
  localparam int STEPW     = 6;
  localparam int PAW       = 3;

  localparam logic [1:0] REQ_LOAD_REST = 2'd0;
  localparam logic [1:0] REQ_LOAD_DEF  = 2'd1;
  localparam logic [1:0] REQ_SETUP     = 2'd2;
  localparam logic [1:0] REQ_EVAL      = 2'd3;

  localparam logic       REG_ACTIVE    = 1'b0;
  localparam logic [4:0] ACTIVE_RESET  = 5'd16;

  typedef struct packed {
    logic             start;
    logic [STEPW-1:0] steps;
    logic [DW-1:0]    init_rem;
    logic [DW-1:0]    divisor;
  } div_req_t;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_LOAD     = 13'b0000000000010,
    S_SU_RD    = 13'b0000000000100,
    S_SU_DIF   = 13'b0000000001000,
    S_SU_MUL   = 13'b0000000010000,
    S_SU_ACC   = 13'b0000000100000,
    S_SU_CHK   = 13'b0000001000000,
    S_SU_DIV   = 13'b0000010000000,
    S_NM_START = 13'b0000100000000,
    S_NM_DIV   = 13'b0001000000000,
    S_EV_RD    = 13'b0010000000000,
    S_EV_MUL   = 13'b0100000000000,
    S_EV_ACC   = 13'b1000000000000
  } state_t;

endpackage

// ----- design/idmd_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module idmd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  idmd_pkg::div_req_t    req,
  output logic                  done,
  output logic [idmd_pkg::QW-1:0] quo
);
  import idmd_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic             first_r;
  logic [STEPW-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    div_r;
  logic [QW-1:0]    quo_r;
  logic [DW:0]      sh;
  logic [DW:0]      dif;
  logic             ge;

  assign sh   = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign dif  = sh - {1'b0, div_r};
  assign ge   = sh >= {1'b0, div_r};
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      first_r <= 1'b1;
      rem_r   <= req.init_rem;
      div_r   <= req.divisor;
      quo_r   <= '0;
    end else if (busy_r) begin
      first_r <= 1'b0;
      rem_r   <= ge ? dif[DW-1:0] : sh[DW-1:0];
      quo_r   <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

// ----- design/inverse_distance_mesh_deformer_top.sv -----
// Top level: inverse-square-distance mesh deformer with sequencer and shared units.
//
// Input channel (in_valid/in_stall) takes one request beat at a time: load a
// rest control, load a deformed control, set up a vertex or evaluate a vertex.
// in_stall is high while a request is in work; a new beat is taken only when
// the sequencer is idle. Only an evaluate returns a beat on the output channel
// (out_valid/out_stall); the result sits in an output register, so the next
// request can start while it waits, and a following evaluate holds its last
// step until that register is free.
// Set-up makes one pass per active control (three coordinate reads, squared
// differences summed, then a divide to a 59-bit quotient), ending early if
// the vertex sits on a control, then normalizes all MAX_CONTROLS weights.
// The shared restoring divider, one quotient bit per cycle, sets the set-up
// time; the single-port control and weight memories set evaluation.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops any
// pending output beat and sets active_controls to 16. Memory contents are
// not cleared and must be written before use. Configuration is an APB-style
// port; write active_controls at address 0 only while the block is idle.
module inverse_distance_mesh_deformer_top #(
  parameter int MAX_CONTROLS = idmd_pkg::MAX_CONTROLS_DEF,
  parameter int MAX_VERTICES = idmd_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = idmd_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_req_type,
  input  logic [7:0]               in_item_index,
  input  logic signed [31:0]       in_x,
  input  logic signed [31:0]       in_y,
  input  logic signed [31:0]       in_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_vertex_index,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [idmd_pkg::PAW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import idmd_pkg::*;

  localparam int CW   = $clog2(MAX_CONTROLS + 1);
  localparam int JW   = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
  localparam int PD   = 3 * MAX_CONTROLS;
  localparam int AW   = $clog2(PD);
  localparam int WD   = MAX_VERTICES * MAX_CONTROLS;
  localparam int WA   = (WD > 1) ? $clog2(WD) : 1;
  localparam int WW   = FRAC_BITS + 1;
  localparam int ACCW = 32 + WW + CW;
  localparam int TW   = 63;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            j_r;
  logic [1:0]               c_r;
  logic [7:0]               vidx_r;
  logic [1:0]               typ_r;
  logic signed [31:0]       vx_r, vy_r, vz_r;
  logic [4:0]               ac_r;
  logic [DW-1:0]            d2_r;
  logic [31:0]              mag_r;
  logic                     sat_r;
  logic signed [65:0]       prod_r;
  logic [TW-1:0]            total_r;
  logic                     hit_r;
  logic [JW-1:0]            hitj_r;
  logic [QW-1:0]            scratch_r [MAX_CONTROLS];
  logic signed [ACCW-1:0]   acc_r;
  logic signed [31:0]       resx_r, resy_r;
  logic                     out_valid_r;
  logic [7:0]               out_vidx_r;
  logic signed [31:0]       out_x_r, out_y_r, out_z_r;

  logic [31:0]              rest_mem [PD];
  logic [31:0]              def_mem  [PD];
  logic [WW-1:0]            w_mem    [WD];
  logic [31:0]              rest_rd_r, def_rd_r;
  logic [WW-1:0]            w_rd_r;

  logic                     in_acc;
  logic [CW-1:0]            n_c;
  logic                     j_last;
  logic                     j_top;
  logic [AW-1:0]            pt_addr;
  logic [WA-1:0]            w_addr;
  logic [31:0]              pt_wdata;
  logic                     rest_we, def_we;
  logic                     w_we;
  logic [WW-1:0]            w_wdata;
  logic signed [31:0]       csel;
  logic signed [32:0]       dd;
  logic signed [32:0]       dm;
  logic signed [32:0]       mul_a, mul_b;
  logic [DW-1:0]            sq;
  logic [DW:0]              d2_sum;
  logic [QW-1:0]            raw_c;
  div_req_t                 dreq;
  logic                     div_done;
  logic [QW-1:0]            div_quo;
  logic signed [ACCW-1:0]   acc_nxt;
  logic signed [ACCW-1:0]   q_sh;
  logic                     sat_hi, sat_lo;
  logic signed [31:0]       res_c;
  logic                     ev_final, ev_block;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign prdata    = {27'd0, ac_r};
  assign out_valid = out_valid_r;
  assign out_vertex_index = out_vidx_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

  always_comb begin
    if (ac_r == 5'd0) begin
      n_c = CW'(1);
    end else if (32'(ac_r) > 32'(MAX_CONTROLS)) begin
      n_c = CW'(MAX_CONTROLS);
    end else begin
      n_c = CW'(ac_r);
    end
  end

  assign j_last  = (j_r == n_c - 1'b1);
  assign j_top   = (32'(j_r) == 32'(MAX_CONTROLS - 1));
  assign pt_addr = AW'(3 * 32'(j_r) + 32'(c_r));
  assign w_addr  = WA'(32'(vidx_r) * MAX_CONTROLS + 32'(j_r));

  always_comb begin
    case (c_r)
      2'd0:    csel = vx_r;
      2'd1:    csel = vy_r;
      default: csel = vz_r;
    endcase
  end

  assign pt_wdata = csel;
  assign rest_we  = (state_r == S_LOAD) && (typ_r == REQ_LOAD_REST);
  assign def_we   = (state_r == S_LOAD) && (typ_r == REQ_LOAD_DEF);

  always_ff @(posedge clk) begin
    if (rest_we) begin
      rest_mem[pt_addr] <= pt_wdata;
    end
    rest_rd_r <= rest_mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (def_we) begin
      def_mem[pt_addr] <= pt_wdata;
    end
    def_rd_r <= def_mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_addr] <= w_wdata;
    end
    w_rd_r <= w_mem[w_addr];
  end

  assign dd = {csel[31], csel} - {rest_rd_r[31], rest_rd_r};
  assign dm = dd[32] ? -dd : dd;

  always_comb begin
    if (state_r == S_SU_MUL) begin
      mul_a = {1'b0, mag_r};
      mul_b = {1'b0, mag_r};
    end else begin
      mul_a = {{(33 - WW){1'b0}}, w_rd_r};
      mul_b = {def_rd_r[31], def_rd_r};
    end
  end

  assign sq     = sat_r ? {DW{1'b1}} : prod_r[DW-1:0];
  assign d2_sum = {1'b0, d2_r} + {1'b0, sq};

  always_comb begin
    if (hit_r) begin
      raw_c = (j_r[JW-1:0] == hitj_r) ? QW'(1) : '0;
    end else if (j_r < n_c) begin
      raw_c = scratch_r[j_r[JW-1:0]];
    end else begin
      raw_c = '0;
    end
  end

  always_comb begin
    dreq.start    = ((state_r == S_SU_CHK) && (d2_r != '0))
                 || ((state_r == S_NM_START) && (total_r != '0));
    dreq.steps    = (state_r == S_SU_CHK) ? STEPW'(RAW_SHIFT) : STEPW'(FRAC_BITS);
    dreq.init_rem = (state_r == S_SU_CHK) ? DW'(1) : DW'(raw_c);
    dreq.divisor  = (state_r == S_SU_CHK) ? d2_r : {1'b0, total_r};
  end

  idmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign w_we    = ((state_r == S_NM_START) && (total_r == '0))
                || ((state_r == S_NM_DIV) && div_done);
  assign w_wdata = (state_r == S_NM_DIV) ? div_quo[WW-1:0] : '0;

  assign acc_nxt = acc_r + ACCW'(prod_r);
  assign q_sh    = acc_nxt >>> FRAC_BITS;
  assign sat_hi  = !q_sh[ACCW-1] && (|q_sh[ACCW-2:31]);
  assign sat_lo  = q_sh[ACCW-1] && !(&q_sh[ACCW-2:31]);
  assign res_c   = sat_hi ? 32'sh7fffffff : (sat_lo ? 32'sh80000000 : q_sh[31:0]);

  assign ev_final = j_last && (c_r == 2'd2);
  assign ev_block = ev_final && out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_LOAD_REST, REQ_LOAD_DEF: begin
              if (32'(in_item_index) < 32'(MAX_CONTROLS)) state_nxt = S_LOAD;
            end
            REQ_SETUP: begin
              if (32'(in_item_index) < 32'(MAX_VERTICES)) state_nxt = S_SU_RD;
            end
            default: begin
              if (32'(in_item_index) < 32'(MAX_VERTICES)) state_nxt = S_EV_RD;
            end
          endcase
        end
      end
      S_LOAD:   if (c_r == 2'd2) state_nxt = S_IDLE;
      S_SU_RD:  state_nxt = S_SU_DIF;
      S_SU_DIF: state_nxt = S_SU_MUL;
      S_SU_MUL: state_nxt = S_SU_ACC;
      S_SU_ACC: state_nxt = (c_r == 2'd2) ? S_SU_CHK : S_SU_RD;
      S_SU_CHK: state_nxt = (d2_r == '0) ? S_NM_START : S_SU_DIV;
      S_SU_DIV: begin
        if (div_done) state_nxt = j_last ? S_NM_START : S_SU_RD;
      end
      S_NM_START: begin
        if (total_r != '0) begin
          state_nxt = S_NM_DIV;
        end else if (j_top) begin
          state_nxt = S_IDLE;
        end
      end
      S_NM_DIV: begin
        if (div_done) state_nxt = j_top ? S_IDLE : S_NM_START;
      end
      S_EV_RD:  state_nxt = S_EV_MUL;
      S_EV_MUL: state_nxt = S_EV_ACC;
      S_EV_ACC: begin
        if (!ev_block) state_nxt = ev_final ? S_IDLE : S_EV_RD;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ac_r        <= ACTIVE_RESET;
      total_r     <= '0;
      hit_r       <= 1'b0;
      j_r         <= '0;
      c_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE)) begin
        ac_r <= pwdata[4:0];
      end
      if (out_valid_r && !out_stall
          && !((state_r == S_EV_ACC) && ev_final && !ev_block)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            c_r     <= '0;
            j_r     <= (in_req_type == REQ_LOAD_REST || in_req_type == REQ_LOAD_DEF)
                       ? CW'(in_item_index) : '0;
            total_r <= '0;
            hit_r   <= 1'b0;
          end
        end
        S_LOAD:   c_r <= c_r + 2'd1;
        S_SU_ACC: c_r <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        S_SU_CHK: begin
          if (d2_r == '0) begin
            hit_r   <= 1'b1;
            total_r <= TW'(1);
            j_r     <= '0;
          end
        end
        S_SU_DIV: begin
          if (div_done) begin
            total_r <= total_r + TW'(div_quo);
            j_r     <= j_last ? '0 : j_r + 1'b1;
          end
        end
        S_NM_START: begin
          if (total_r == '0) j_r <= j_r + 1'b1;
        end
        S_NM_DIV: begin
          if (div_done) j_r <= j_r + 1'b1;
        end
        S_EV_ACC: begin
          if (!ev_block) begin
            if (j_last) begin
              j_r <= '0;
              c_r <= c_r + 2'd1;
              if (c_r == 2'd2) out_valid_r <= 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      typ_r  <= in_req_type;
      vidx_r <= in_item_index;
      vx_r   <= in_x;
      vy_r   <= in_y;
      vz_r   <= in_z;
      d2_r   <= '0;
      acc_r  <= '0;
    end
    if (state_r == S_SU_DIF) begin
      mag_r <= dm[31:0];
      sat_r <= dm[32];
    end
    if (state_r == S_SU_ACC) begin
      d2_r <= d2_sum[DW] ? {DW{1'b1}} : d2_sum[DW-1:0];
    end
    if (state_r == S_SU_CHK) begin
      hitj_r <= j_r[JW-1:0];
    end
    if ((state_r == S_SU_DIV) && div_done) begin
      scratch_r[j_r[JW-1:0]] <= div_quo;
      d2_r                   <= '0;
    end
    if ((state_r == S_EV_ACC) && !ev_block) begin
      if (j_last) begin
        acc_r <= '0;
        case (c_r)
          2'd0: resx_r <= res_c;
          2'd1: resy_r <= res_c;
          default: begin
            out_vidx_r <= vidx_r;
            out_x_r    <= resx_r;
            out_y_r    <= resy_r;
            out_z_r    <= res_c;
          end
        endcase
      end else begin
        acc_r <= acc_nxt;
      end
    end
  end

endmodule
